[design/rpnp_pkg.sv]
// Shared widths, character codes and constants of the radix-prefixed number parser.
package rpnp_pkg;

  localparam int CHAR_W          = 8;
  localparam int VALUE_W         = 32;
  localparam int CONSUMED_W      = 16;
  localparam int DIGIT_W         = 4;
  localparam int COUNT_WIDTH_DEF = 16;

  typedef logic [CHAR_W-1:0]     char_t;
  typedef logic [VALUE_W-1:0]    value_t;
  typedef logic [CONSUMED_W-1:0] consumed_t;
  typedef logic [DIGIT_W-1:0]    digit_t;

  localparam char_t CH_NUL   = 8'h00;
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_LF    = 8'h0A;
  localparam char_t CH_VT    = 8'h0B;
  localparam char_t CH_CR    = 8'h0D;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_ONE   = 8'h31;
  localparam char_t CH_NINE  = 8'h39;
  localparam char_t CH_UA    = 8'h41;
  localparam char_t CH_UF    = 8'h46;
  localparam char_t CH_LA    = 8'h61;
  localparam char_t CH_LB    = 8'h62;
  localparam char_t CH_LF_HI = 8'h66;
  localparam char_t CH_LX    = 8'h78;

  // Base value of the letter digits a..f and A..F: a and A are 10.
  localparam digit_t HEX_LETTER_BASE = 4'd10;

endpackage

[design/rpnp_if.sv]
// Valid/ready channel interfaces for the character items and the parse results.
interface rpnp_in_if;
  import rpnp_pkg::*;

  logic  valid;
  logic  ready;
  char_t char_code;
  logic  last_of_buffer;

  modport source (output valid, output char_code, output last_of_buffer, input ready);
  modport sink   (input valid, input char_code, input last_of_buffer, output ready);
endinterface

interface rpnp_out_if;
  import rpnp_pkg::*;

  logic      valid;
  logic      ready;
  value_t    value;
  consumed_t consumed;
  logic      accepted;

  modport source (output valid, output value, output consumed, output accepted, input ready);
  modport sink   (input valid, input value, input consumed, input accepted, output ready);
endinterface

[design/radix_prefixed_number_parser_unit.sv]
// Radix-prefixed number parser top level: streams buffer characters and returns one parse result.
// The block reads a text buffer one character per item and parses an unsigned
// number at its start. A leading "0x" or "0b" selects hexadecimal or binary when
// the buffer holds more than two characters; otherwise the number is decimal.
// Digits accumulate modulo 2^32. The first non-digit ends the number, and the
// parse is accepted only if that character is NUL, space, tab, vertical tab, CR
// or LF, or if the buffer ended while still in digits. A rejected parse reports
// value 0 and count 0. Characters after the end of the number are ignored.
// Exactly one result item is produced per buffer, on the item that carries
// last_of_buffer, and the parser then starts fresh for the next buffer.
// Throughput is one character per clock: the parse state is updated by a single
// shift-and-add step in the cycle a character is accepted, and the result is
// registered in the output register, or in the skid register while the output
// register is held. The two-entry output buffer (output register plus skid) keeps
// in_chan.ready a registered signal, so characters keep flowing while one finished
// result waits downstream; input stalls only when both entries hold results.
// The consumed count saturates at 2^COUNT_WIDTH - 1 and is then reported in its low 16 bits.
module radix_prefixed_number_parser_unit #(
  parameter int COUNT_WIDTH = rpnp_pkg::COUNT_WIDTH_DEF
) (
  input logic          clk,
  input logic          rst_n,
  rpnp_in_if.sink      in_chan,
  rpnp_out_if.source   out_chan
);

  import rpnp_pkg::*;

  localparam logic [2:0] MODE_START = 3'd0;
  localparam logic [2:0] MODE_DEC   = 3'd1;
  localparam logic [2:0] MODE_HEX   = 3'd2;
  localparam logic [2:0] MODE_BIN   = 3'd3;
  localparam logic [2:0] MODE_OK    = 3'd4;
  localparam logic [2:0] MODE_REJ   = 3'd5;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_TWO = COUNT_WIDTH'(2);

  // Parse state.
  logic [2:0]             mode_r,  mode_nxt;
  value_t                 acc_r,   acc_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic                   fwz_r,   fwz_nxt;

  // Output register and skid register.
  logic      out_valid_r,  out_valid_nxt;
  value_t    out_value_r,  out_value_nxt;
  consumed_t out_cons_r,   out_cons_nxt;
  logic      out_acc_r,    out_acc_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  value_t    skid_value_r, skid_value_nxt;
  consumed_t skid_cons_r,  skid_cons_nxt;
  logic      skid_acc_r,   skid_acc_nxt;

  // Per-character step.
  char_t                  ch;
  logic                   last;
  logic                   in_fire, out_fire, push;
  logic [2:0]             mode_eff, mode_step;
  logic                   fwz_eff;
  logic                   active, prefix_hit, is_digit, is_term;
  digit_t                 dval;
  value_t                 acc_step;
  logic [COUNT_WIDTH-1:0] count_step;
  logic [COUNT_WIDTH+CONSUMED_W-1:0] count_ext;
  value_t                 res_value;
  consumed_t              res_cons;
  logic                   res_acc;

  assign ch       = in_chan.char_code;
  assign last     = in_chan.last_of_buffer;
  assign in_chan.ready = !skid_valid_r;
  assign in_fire  = in_chan.valid && !skid_valid_r;
  assign out_fire = out_valid_r && out_chan.ready;
  assign push     = in_fire && last;

  // Digit decoding for the mode in effect on this character.
  always_comb begin
    is_digit = 1'b0;
    dval     = '0;
    unique case (mode_eff)
      MODE_BIN: begin
        if (ch == CH_ZERO || ch == CH_ONE) begin
          is_digit = 1'b1;
          dval     = DIGIT_W'(ch - CH_ZERO);
        end
      end
      MODE_HEX: begin
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
          is_digit = 1'b1;
          dval     = DIGIT_W'(ch - CH_ZERO);
        end else if (ch >= CH_LA && ch <= CH_LF_HI) begin
          is_digit = 1'b1;
          dval     = DIGIT_W'(ch - CH_LA) + HEX_LETTER_BASE;
        end else if (ch >= CH_UA && ch <= CH_UF) begin
          is_digit = 1'b1;
          dval     = DIGIT_W'(ch - CH_UA) + HEX_LETTER_BASE;
        end
      end
      default: begin
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
          is_digit = 1'b1;
          dval     = DIGIT_W'(ch - CH_ZERO);
        end
      end
    endcase
  end

  always_comb begin
    // The first character of a buffer starts a decimal parse.
    mode_eff = (mode_r == MODE_START) ? MODE_DEC : mode_r;
    fwz_eff  = (mode_r == MODE_START) ? (ch == CH_ZERO) : fwz_r;
    active   = (mode_eff == MODE_DEC) || (mode_eff == MODE_HEX) || (mode_eff == MODE_BIN);
    is_term  = (ch == CH_NUL) || (ch == CH_SPACE) || (ch == CH_TAB) ||
               (ch == CH_VT) || (ch == CH_CR) || (ch == CH_LF);
    // A radix letter right after a leading zero, with more characters to come.
    prefix_hit = (mode_eff == MODE_DEC) && fwz_eff && (count_r == COUNT_ONE) && !last &&
                 (ch == CH_LX || ch == CH_LB);

    mode_step  = mode_eff;
    acc_step   = acc_r;
    count_step = count_r;
    if (active) begin
      priority if (prefix_hit) begin
        mode_step  = (ch == CH_LX) ? MODE_HEX : MODE_BIN;
        acc_step   = '0;
        count_step = COUNT_TWO;
      end else if (is_digit) begin
        unique case (mode_eff)
          MODE_HEX: acc_step = {acc_r[VALUE_W-5:0], dval};
          MODE_BIN: acc_step = {acc_r[VALUE_W-2:0], dval[0]};
          default:  acc_step = (acc_r << 3) + (acc_r << 1) + VALUE_W'(dval);
        endcase
        if (count_r != COUNT_MAX) begin
          count_step = count_r + COUNT_ONE;
        end
      end else if (is_term) begin
        mode_step = MODE_OK;
      end else begin
        mode_step  = MODE_REJ;
        acc_step   = '0;
        count_step = '0;
      end
    end

    count_ext = {{CONSUMED_W{1'b0}}, count_step};
    res_value = acc_step;
    res_cons  = count_ext[CONSUMED_W-1:0];
    res_acc   = (mode_step != MODE_REJ);

    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    count_nxt = count_r;
    fwz_nxt   = fwz_r;
    if (in_fire) begin
      if (last) begin
        mode_nxt  = MODE_START;
        acc_nxt   = '0;
        count_nxt = '0;
        fwz_nxt   = 1'b0;
      end else begin
        mode_nxt  = mode_step;
        acc_nxt   = acc_step;
        count_nxt = count_step;
        fwz_nxt   = fwz_eff;
      end
    end
  end

  // Two-entry result buffer. The skid entry only fills when the output register
  // is held by a stalled consumer, and it drains into the output register first.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_cons_nxt   = out_cons_r;
    out_acc_nxt    = out_acc_r;
    skid_valid_nxt = skid_valid_r;
    skid_value_nxt = skid_value_r;
    skid_cons_nxt  = skid_cons_r;
    skid_acc_nxt   = skid_acc_r;
    if (skid_valid_r) begin
      if (out_fire) begin
        out_value_nxt  = skid_value_r;
        out_cons_nxt   = skid_cons_r;
        out_acc_nxt    = skid_acc_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (out_valid_r && !out_chan.ready) begin
      if (push) begin
        skid_valid_nxt = 1'b1;
        skid_value_nxt = res_value;
        skid_cons_nxt  = res_cons;
        skid_acc_nxt   = res_acc;
      end
    end else if (push) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = res_value;
      out_cons_nxt  = res_cons;
      out_acc_nxt   = res_acc;
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_START;
      acc_r        <= '0;
      count_r      <= '0;
      fwz_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      mode_r       <= mode_nxt;
      acc_r        <= acc_nxt;
      count_r      <= count_nxt;
      fwz_r        <= fwz_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_cons_r   <= out_cons_nxt;
    out_acc_r    <= out_acc_nxt;
    skid_value_r <= skid_value_nxt;
    skid_cons_r  <= skid_cons_nxt;
    skid_acc_r   <= skid_acc_nxt;
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.value    = out_value_r;
  assign out_chan.consumed = out_cons_r;
  assign out_chan.accepted = out_acc_r;

endmodule

[tb/radix_prefixed_number_parser_unit_tb.sv]
// Self-checking testbench for the radix-prefixed number parser unit.
`timescale 1ns / 100ps

module radix_prefixed_number_parser_unit_tb;
  import rpnp_pkg::*;

  // Run shape. The random part stops once about RANDOM_ITEMS characters of
  // ordinary buffers have been offered.
  localparam int          COUNT_W      = COUNT_WIDTH_DEF;
  localparam int          RANDOM_ITEMS = 1600;
  localparam int          HOLD_AT      = 300;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 32;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_W) - 64'd1);
  localparam value_t      DEC_RADIX = 10;

  // Bytes that the package does not name: a letter that is never a digit and
  // the top of the byte range.
  localparam char_t CH_BAD_G = 8'h67;
  localparam char_t CH_TOP   = 8'hFF;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_DEC, SCAN_HEX, SCAN_BIN, SCAN_DONE, SCAN_BAD
  } scan_state_t;

  typedef struct packed {
    value_t    value;
    consumed_t consumed;
    logic      accepted;
  } parse_result_t;

  // One row of the directed table. A pinned row carries a hand-written result
  // that replaces the predicted one.
  typedef struct {
    char_t         ch;
    logic          last;
    bit            pinned;
    parse_result_t want;
  } stim_row_t;

  typedef struct {
    bit            on;
    parse_result_t want;
  } pin_t;

  logic clk;
  logic rst_n;

  rpnp_in_if  in_if ();
  rpnp_out_if out_if ();

  radix_prefixed_number_parser_unit #(
    .COUNT_WIDTH(COUNT_W)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Parser state as the stream has shaped it so far.
  scan_state_t scan_st        = SCAN_IDLE;
  value_t      scan_acc       = '0;
  logic [31:0] scan_cnt       = '0;
  bit          scan_lead_zero = 1'b0;

  parse_result_t pending_results[$];
  pin_t          item_pins[$];

  int unsigned items_sent     = 0;
  int unsigned short_items    = 0;
  int unsigned buffers_sent   = 0;
  int unsigned results_seen   = 0;
  int unsigned accepted_seen  = 0;
  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;
  int unsigned longest_buffer = 0;

  // Flow control between the processes.
  logic        hold_off     = 1'b0;
  int unsigned calm_items   = 0;
  int unsigned rx_stall_left = 0;
  int unsigned rx_calm_left  = 0;
  int unsigned rx_roll;

  function automatic bit is_blank(char_t c);
    return c == CH_NUL || c == CH_SPACE || c == CH_TAB || c == CH_VT ||
           c == CH_CR || c == CH_LF;
  endfunction

  // Digit value of a byte in the current radix. Binary takes only 0 and 1,
  // hex adds letters of either case, decimal takes 0..9.
  function automatic bit digit_of(scan_state_t st, char_t c, output digit_t d);
    d = '0;
    if (st == SCAN_BIN) begin
      if (c == CH_ZERO || c == CH_ONE) begin
        d = digit_t'(c - CH_ZERO);
        return 1'b1;
      end
      return 1'b0;
    end
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = digit_t'(c - CH_ZERO);
      return 1'b1;
    end
    if (st == SCAN_HEX) begin
      if (c >= CH_LA && c <= CH_LF_HI) begin
        d = digit_t'(c - CH_LA) + HEX_LETTER_BASE;
        return 1'b1;
      end
      if (c >= CH_UA && c <= CH_UF) begin
        d = digit_t'(c - CH_UA) + HEX_LETTER_BASE;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Advances the parser by one byte. Returns 1 with the buffer's result when
  // the byte closes the buffer, after which the parser starts over.
  function automatic bit scan_char(char_t c, logic last, output parse_result_t res);
    digit_t d;
    res = '0;
    if (scan_st == SCAN_IDLE) begin
      scan_st        = SCAN_DEC;
      scan_lead_zero = (c == CH_ZERO);
    end
    if (scan_st == SCAN_DEC || scan_st == SCAN_HEX || scan_st == SCAN_BIN) begin
      // A radix letter right after a leading zero switches mode, but only
      // when more bytes follow in the buffer.
      if (scan_st == SCAN_DEC && scan_lead_zero && scan_cnt == 1 && !last &&
          (c == CH_LX || c == CH_LB)) begin
        scan_st  = (c == CH_LX) ? SCAN_HEX : SCAN_BIN;
        scan_acc = '0;
        scan_cnt = 2;
      end else if (digit_of(scan_st, c, d)) begin
        case (scan_st)
          SCAN_DEC: scan_acc = scan_acc * DEC_RADIX + value_t'(d);
          SCAN_HEX: scan_acc = (scan_acc << 4) | value_t'(d);
          default:  scan_acc = (scan_acc << 1) | value_t'(d);
        endcase
        if (scan_cnt < COUNT_MAX) scan_cnt++;
      end else if (is_blank(c)) begin
        scan_st = SCAN_DONE;
      end else begin
        scan_st  = SCAN_BAD;
        scan_acc = '0;
        scan_cnt = '0;
      end
    end
    if (!last) return 1'b0;
    res.value      = scan_acc;
    res.consumed   = consumed_t'(scan_cnt);
    res.accepted   = (scan_st != SCAN_BAD);
    scan_st        = SCAN_IDLE;
    scan_acc       = '0;
    scan_cnt       = '0;
    scan_lead_zero = 1'b0;
    return 1'b1;
  endfunction

  function automatic stim_row_t plain(char_t c, logic last);
    stim_row_t r;
    r.ch     = c;
    r.last   = last;
    r.pinned = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  // Closing byte of a buffer whose result is written out by hand.
  function automatic stim_row_t pinned(char_t c, value_t v, consumed_t n, logic ok);
    stim_row_t r;
    r.ch     = c;
    r.last   = 1'b1;
    r.pinned = 1'b1;
    r.want   = '{value: v, consumed: n, accepted: ok};
    return r;
  endfunction

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic char_t hex_char(int unsigned d);
    if (d < 10) return char_t'(CH_ZERO + d);
    return char_t'(($urandom_range(0, 1) ? CH_LA : CH_UA) + d - 10);
  endfunction

  function automatic char_t any_byte();
    return char_t'($urandom_range(0, 255));
  endfunction

  // End of a well-formed number: either the buffer stops on the last digit,
  // or a terminator (or a bad byte) follows with some junk after it.
  function automatic void append_tail(ref char_t b[$]);
    char_t       terms[6];
    int unsigned r;
    int unsigned junk;
    terms = '{CH_NUL, CH_SPACE, CH_TAB, CH_VT, CH_CR, CH_LF};
    r     = $urandom_range(0, 99);
    if (r < 30) return;
    b.push_back(r < 80 ? terms[$urandom_range(0, 5)] : any_byte());
    junk = $urandom_range(0, 4);
    repeat (junk) b.push_back(any_byte());
  endfunction

  // Draws one random buffer. Most are well-formed numbers in one of the three
  // radixes with random digits; the rest are bare prefixes, broken numbers
  // and plain noise.
  function automatic void build_buffer(ref char_t b[$]);
    int unsigned kind;
    int unsigned n;
    b.delete();
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      // Long runs of decimal digits wrap the value modulo 2^32.
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 22) : $urandom_range(1, 10);
      repeat (n) b.push_back(char_t'(CH_ZERO + $urandom_range(0, 9)));
      append_tail(b);
    end else if (kind < 55) begin
      b.push_back(CH_ZERO);
      b.push_back(CH_LX);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(0, 8);
      repeat (n) b.push_back(hex_char($urandom_range(0, 15)));
      append_tail(b);
    end else if (kind < 70) begin
      b.push_back(CH_ZERO);
      b.push_back(CH_LB);
      n = $urandom_range(0, 40);
      repeat (n) b.push_back($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
      append_tail(b);
    end else if (kind < 75) begin
      // Bare prefix or a lone zero: too short for a radix switch.
      b.push_back(CH_ZERO);
      if ($urandom_range(0, 3) != 0) b.push_back($urandom_range(0, 1) ? CH_LX : CH_LB);
    end else if (kind < 85) begin
      // Broken number: an optional prefix, up to four 0/1 digits, then one to four random bytes.
      if ($urandom_range(0, 1)) begin
        b.push_back(CH_ZERO);
        b.push_back($urandom_range(0, 1) ? CH_LX : CH_LB);
      end
      n = $urandom_range(0, 4);
      repeat (n) b.push_back(char_t'(CH_ZERO + $urandom_range(0, 1)));
      n = $urandom_range(1, 4);
      repeat (n) b.push_back(any_byte());
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) b.push_back(any_byte());
    end
  endfunction

  // Offers one item and waits for the handshake. The pin record travels in
  // step with the item so the monitor knows whether a typed result applies.
  task automatic offer_char(char_t c, logic last, bit pin_on, parse_result_t want);
    int unsigned gap;
    int unsigned r;
    item_pins.push_back('{on: pin_on, want: want});
    in_if.valid          <= 1'b1;
    in_if.char_code      <= c;
    in_if.last_of_buffer <= last;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
    if (last) buffers_sent++;
    gap = 0;
    if (!hold_off) begin
      if (calm_items != 0) begin
        calm_items--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) calm_items = $urandom_range(20, 80);
        else if (r < 35) gap = idle_len();
      end
    end
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Input monitor and result checker share one process, input side first, so
  // an expectation is always queued before a result in the same cycle is
  // checked against it.
  parse_result_t predicted;
  parse_result_t want_res;
  pin_t          pin;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        pin = item_pins.pop_front();
        if (scan_char(in_if.char_code, in_if.last_of_buffer, predicted))
          pending_results.push_back(pin.on ? pin.want : predicted);
      end
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (out_if.accepted === 1'b1) accepted_seen++;
        if (pending_results.size() == 0) begin
          $error("result with no expectation waiting: value %0d consumed %0d accepted %0b",
                 out_if.value, out_if.consumed, out_if.accepted);
          fail_count++;
        end else begin
          want_res = pending_results.pop_front();
          if (out_if.value !== want_res.value) begin
            $error("value mismatch: expected %0d, got %0d", want_res.value, out_if.value);
            fail_count++;
          end
          if (out_if.consumed !== want_res.consumed) begin
            $error("consumed mismatch: expected %0d, got %0d",
                   want_res.consumed, out_if.consumed);
            fail_count++;
          end
          if (out_if.accepted !== want_res.accepted) begin
            $error("accepted mismatch: expected %0b, got %0b",
                   want_res.accepted, out_if.accepted);
            fail_count++;
          end
        end
      end
    end
  end

  // Result side: random stalls, mostly short, some long, with stretches of
  // steady readiness. The long hold-off overrides all of it.
  always @(posedge clk) begin
    if (!rst_n || hold_off) begin
      out_if.ready <= 1'b0;
    end else if (rx_stall_left != 0) begin
      rx_stall_left--;
      out_if.ready <= 1'b0;
    end else if (rx_calm_left != 0) begin
      rx_calm_left--;
      out_if.ready <= 1'b1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 5) rx_calm_left = $urandom_range(20, 80);
      if (rx_roll < 70) begin
        out_if.ready <= 1'b1;
      end else begin
        rx_stall_left = idle_len() - 1;
        out_if.ready <= 1'b0;
      end
    end
  end

  // Back-pressure episode: the receiver stops for a long stretch while the
  // sender keeps offering items without gaps, so the block has to fill up and
  // push back on its input.
  initial begin
    wait (items_sent >= HOLD_AT);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results still expected",
             cycle_count, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Main stimulus: reset, directed table, random buffers, then drain.
  initial begin
    stim_row_t dir_rows[$];
    char_t     chars[$];

    rst_n                <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.char_code      <= '0;
    in_if.last_of_buffer <= 1'b0;

    // Directed buffers: terminator first, NUL alone, a prefix as the whole
    // buffer, a prefix with no digits, binary and hex numbers, a top-range
    // byte, a rejected decimal and junk after an accepted terminator.
    dir_rows = '{
      pinned(CH_SPACE, 0, 0, 1'b1),
      pinned(CH_NUL, 0, 0, 1'b1),
      plain(CH_ZERO, 1'b0), pinned(CH_LX, 0, 0, 1'b0),
      plain(CH_ZERO, 1'b0), plain(CH_LX, 1'b0), pinned(CH_TAB, 0, 2, 1'b1),
      plain(CH_ZERO, 1'b0), plain(CH_LB, 1'b0), plain(CH_ONE, 1'b0),
      plain(CH_ZERO, 1'b0), plain(CH_VT, 1'b1),
      pinned(CH_TOP, 0, 0, 1'b0),
      plain(CH_ZERO, 1'b0), plain(CH_LX, 1'b0), plain(CH_LF_HI, 1'b0),
      plain(CH_UF, 1'b0), plain(CH_NUL, 1'b1),
      plain(CH_NINE, 1'b0), plain(CH_NINE, 1'b0), pinned(CH_BAD_G, 0, 0, 1'b0),
      plain(CH_ONE, 1'b0), plain(CH_CR, 1'b0), plain(CH_TOP, 1'b1)
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      offer_char(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].pinned, dir_rows[i].want);

    while (short_items < RANDOM_ITEMS) begin
      build_buffer(chars);
      short_items += chars.size();
      if (chars.size() > longest_buffer) longest_buffer = chars.size();
      foreach (chars[i]) offer_char(chars[i], i == chars.size() - 1, 1'b0, '0);
    end
    in_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      fail_count++;
    end

    $display("Run covered %0d buffers in %0d characters, the longest %0d characters long.",
             buffers_sent, items_sent, longest_buffer);
    $display("%0d results checked (%0d accepted, %0d rejected), %0d mismatches.",
             results_seen, accepted_seen, results_seen - accepted_seen, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
design/rpnp_pkg.sv
design/rpnp_if.sv
design/radix_prefixed_number_parser_unit.sv
tb/radix_prefixed_number_parser_unit_tb.sv
